>>> design/assert_macros.svh
// assertion macros shared by the line position pid design
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/lpp_pkg.sv
// shared constants, register codes and unit request types of the line position pid
// no dependencies
`default_nettype none

package lpp_pkg;

	localparam int SENSOR_COUNT = 6;
	localparam int SAMPLE_BITS  = 12;

	localparam int THRESH_W   = 12;
	localparam int GAIN_W     = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int DRIVE_W   = 25;
	localparam int ERR_W     = 14;
	localparam int CNT_W     = 3;
	localparam int INTEG_W   = 16;
	localparam int DERIV_W   = 15;
	localparam int SUM_W     = 7;
	localparam int MAG_W     = 6;
	localparam int ERR_FRAC  = 8;
	localparam int DIV_W     = MAG_W + ERR_FRAC;
	localparam int DIVISOR_W = CNT_W;
	localparam int MUL_W     = 16;
	localparam int PROD_W    = GAIN_W + 1 + MUL_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int Q_SHIFT   = 16;

	localparam int INTEG_LIMIT = 25600;
	localparam int DRIVE_MAX   = 16777215;
	localparam int DRIVE_MIN   = -16777216;
	localparam int COUNT_NULL  = 4;

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(500);
	localparam logic [GAIN_W-1:0]   GAIN_P_RESET = GAIN_W'(1048576);
	localparam logic [GAIN_W-1:0]   GAIN_I_RESET = GAIN_W'(256);
	localparam logic [GAIN_W-1:0]   GAIN_D_RESET = GAIN_W'(2949120);

	localparam logic signed [SUM_W-1:0] LINE_WEIGHT [SENSOR_COUNT] = '{
		7'sd17, 7'sd10, 7'sd6, -7'sd6, -7'sd10, -7'sd17
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_THRESHOLD = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic                    clear;
		logic                    issue;
		logic [GAIN_W-1:0]       gain;
		logic signed [MUL_W-1:0] operand;
	} mac_req_t;

	typedef struct packed {
		logic                    busy;
		logic signed [ACC_W-1:0] acc;
	} mac_rsp_t;

endpackage

`default_nettype wire

>>> design/lpp_ifs.sv
// valid/ready channels for sensor scans and pid results
// depends on lpp_pkg
`default_nettype none

interface lpp_scan_if import lpp_pkg::*; #(
	parameter int SB = SAMPLE_BITS
);
	logic          valid;
	logic          ready;
	logic [SB-1:0] sample_0;
	logic [SB-1:0] sample_1;
	logic [SB-1:0] sample_2;
	logic [SB-1:0] sample_3;
	logic [SB-1:0] sample_4;
	logic [SB-1:0] sample_5;

	modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, input ready);
	modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, output ready);
endinterface

interface lpp_result_if import lpp_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive_value;
	logic signed [ERR_W-1:0]   line_error;
	logic [CNT_W-1:0]          sensors_on_line;

	modport source (output valid, drive_value, line_error, sensors_on_line, input ready);
	modport sink (input valid, drive_value, line_error, sensors_on_line, output ready);
endinterface

`default_nettype wire

>>> design/lpp_div.sv
// restoring divider, one quotient bit per cycle, for the averaged line error
// depends on lpp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lpp_div import lpp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_DW = $clog2(DIV_W + 1);

	logic [CNT_DW-1:0]    cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W-1:0]     work_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;

	logic [DIVISOR_W:0]   trial_c;
	logic                 qbit_c;
	logic [DIVISOR_W:0]   diff_c;

	always_comb begin
		trial_c = {rem_q, work_q[DIV_W-1]};
		diff_c  = trial_c - {1'b0, divisor_q};
		qbit_c  = (trial_c >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_DW'(DIV_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_DW'(1);
			if (cnt_q == CNT_DW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], qbit_c};
			rem_q  <= qbit_c ? diff_c[DIVISOR_W-1:0] : trial_c[DIVISOR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

	`ASSERT_NEXT(a_start_drops_done, req.start, !done_q && busy_q, "divider start did not restart")
	`ASSERT_ALWAYS(a_busy_done_excl, !(busy_q && done_q), "divider busy and done together")
	`ASSERT_SAME(a_busy_counts, busy_q, cnt_q != '0, "divider busy with no steps left")

endmodule

`default_nettype wire

>>> design/lpp_mac.sv
// shared multiply-accumulate unit for the three pid terms
// depends on lpp_pkg
`default_nettype none

module lpp_mac import lpp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mac_req_t req,
	output mac_rsp_t      rsp
);

	logic signed [GAIN_W:0]   gain_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     valid_s1;
	logic signed [ACC_W-1:0]  acc_q;

	assign gain_c = $signed({1'b0, req.gain});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod_s1 <= gain_c * req.operand;
		end
		if (req.clear) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign rsp.busy = valid_s1;
	assign rsp.acc  = acc_q;

endmodule

`default_nettype wire

>>> design/line_position_pid_core.sv
// line position pid core: sensor compare, 14-step divider, one shared multiplier for pid
// flow: an accepted scan passes sum, divide, pid, three multiply steps (p, i, d), drain and
// fin to a registered result beat; the divider is skipped when no sensor or exactly four are on the line
// a new scan is taken only in idle, once the previous result is registered, later while a result waits
// reset: config to defaults, integral and previous error to zero, no result pending
// depends on lpp_pkg, lpp_ifs, lpp_div, lpp_mac and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module line_position_pid_core import lpp_pkg::*; #(
	parameter int SAMPLE_BITS = lpp_pkg::SAMPLE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	lpp_scan_if.sink                   scan,
	lpp_result_if.source               result
);

	localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	localparam logic signed [ACC_W-1:0]   DRIVE_HI = ACC_W'(DRIVE_MAX);
	localparam logic signed [ACC_W-1:0]   DRIVE_LO = ACC_W'(DRIVE_MIN);
	localparam logic signed [INTEG_W:0]   INTEG_HI = (INTEG_W + 1)'(INTEG_LIMIT);
	localparam logic signed [INTEG_W:0]   INTEG_LO = (INTEG_W + 1)'(-INTEG_LIMIT);
	localparam logic signed [INTEG_W-1:0] INTEG_HI_N = INTEG_W'(INTEG_LIMIT);
	localparam logic signed [INTEG_W-1:0] INTEG_LO_N = INTEG_W'(-INTEG_LIMIT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_PID,
		S_MUL,
		S_DRAIN,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_I,
		TERM_D
	} term_t;

	// configuration
	logic [THRESH_W-1:0] thresh_q;
	logic [GAIN_W-1:0]   gain_p_q;
	logic [GAIN_W-1:0]   gain_i_q;
	logic [GAIN_W-1:0]   gain_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			gain_p_q <= GAIN_P_RESET;
			gain_i_q <= GAIN_I_RESET;
			gain_d_q <= GAIN_D_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				REG_GAIN_P:         gain_p_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:         gain_i_q <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:         gain_d_q <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	state_t                    state_q;
	term_t                     step_q;
	logic [SENSOR_COUNT-1:0]   hits_q;
	logic [CNT_W-1:0]          count_q;
	logic                      neg_q;
	logic                      zero_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [INTEG_W-1:0] int_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [ERR_W-1:0]   line_err_q;
	logic [CNT_W-1:0]          cnt_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mac_req_t mac_req;
	mac_rsp_t mac_rsp;

	// sensor compare
	logic [CMP_W-1:0]        samples_c [SENSOR_COUNT];
	logic [SENSOR_COUNT-1:0] hit_c;

	always_comb begin
		samples_c[0] = CMP_W'(scan.sample_0);
		samples_c[1] = CMP_W'(scan.sample_1);
		samples_c[2] = CMP_W'(scan.sample_2);
		samples_c[3] = CMP_W'(scan.sample_3);
		samples_c[4] = CMP_W'(scan.sample_4);
		samples_c[5] = CMP_W'(scan.sample_5);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			hit_c[i] = (samples_c[i] <= CMP_W'(thresh_q));
		end
	end

	// weight sum and count of sensors on the line
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] abs_c;
	logic [CNT_W-1:0]        count_c;
	logic                    zero_c;

	always_comb begin
		sum_c   = '0;
		count_c = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (hits_q[i]) begin
				sum_c   = sum_c + LINE_WEIGHT[i];
				count_c = count_c + CNT_W'(1);
			end
		end
		abs_c  = sum_c[SUM_W-1] ? -sum_c : sum_c;
		zero_c = (count_c == '0) || (count_c == CNT_W'(COUNT_NULL));
	end

	// error, integral and derivative
	logic signed [ERR_W-1:0]   quo_c;
	logic signed [ERR_W-1:0]   err_c;
	logic signed [INTEG_W:0]   isum_c;
	logic signed [INTEG_W-1:0] integ_c;
	logic signed [DERIV_W-1:0] deriv_c;

	always_comb begin
		quo_c  = $signed(div_rsp.quotient[ERR_W-1:0]);
		err_c  = zero_q ? '0 : (neg_q ? -quo_c : quo_c);
		isum_c = (INTEG_W + 1)'(int_q) + (INTEG_W + 1)'(err_c);
		if (isum_c > INTEG_HI) begin
			integ_c = INTEG_HI_N;
		end else if (isum_c < INTEG_LO) begin
			integ_c = INTEG_LO_N;
		end else begin
			integ_c = isum_c[INTEG_W-1:0];
		end
		deriv_c = DERIV_W'(err_c) - DERIV_W'(prev_q);
	end

	// unit requests
	always_comb begin
		div_req.start    = (state_q == S_SUM) && !zero_c;
		div_req.dividend = {abs_c[MAG_W-1:0], {ERR_FRAC{1'b0}}};
		div_req.divisor  = count_c;

		mac_req.issue = (state_q == S_MUL);
		mac_req.clear = (state_q == S_MUL) && (step_q == TERM_P);
		case (step_q)
			TERM_P: begin
				mac_req.gain    = gain_p_q;
				mac_req.operand = MUL_W'(err_q);
			end
			TERM_I: begin
				mac_req.gain    = gain_i_q;
				mac_req.operand = MUL_W'(int_q);
			end
			TERM_D: begin
				mac_req.gain    = gain_d_q;
				mac_req.operand = MUL_W'(deriv_q);
			end
			default: begin
				mac_req.gain    = '0;
				mac_req.operand = '0;
			end
		endcase
	end

	lpp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lpp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	// floor of the q24 sum to q8, then saturate
	logic signed [ACC_W-1:0]   shifted_c;
	logic signed [DRIVE_W-1:0] drive_c;

	always_comb begin
		shifted_c = mac_rsp.acc >>> Q_SHIFT;
		if (shifted_c > DRIVE_HI) begin
			drive_c = DRIVE_W'(DRIVE_MAX);
		end else if (shifted_c < DRIVE_LO) begin
			drive_c = DRIVE_W'(DRIVE_MIN);
		end else begin
			drive_c = shifted_c[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= TERM_P;
			hits_q      <= '0;
			count_q     <= '0;
			neg_q       <= 1'b0;
			zero_q      <= 1'b0;
			err_q       <= '0;
			int_q       <= '0;
			prev_q      <= '0;
			deriv_q     <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			line_err_q  <= '0;
			cnt_out_q   <= '0;
		end else begin
			if (result.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (scan.valid) begin
						hits_q  <= hit_c;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					count_q <= count_c;
					neg_q   <= sum_c[SUM_W-1];
					zero_q  <= zero_c;
					state_q <= zero_c ? S_PID : S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_PID;
					end
				end
				S_PID: begin
					err_q   <= err_c;
					int_q   <= integ_c;
					deriv_q <= deriv_c;
					prev_q  <= err_c;
					step_q  <= TERM_P;
					state_q <= S_MUL;
				end
				S_MUL: begin
					case (step_q)
						TERM_P:  step_q <= TERM_I;
						TERM_I:  step_q <= TERM_D;
						default: state_q <= S_DRAIN;
					endcase
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						drive_q     <= drive_c;
						line_err_q  <= err_q;
						cnt_out_q   <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign scan.ready             = (state_q == S_IDLE);
	assign result.valid           = out_valid_q;
	assign result.drive_value     = drive_q;
	assign result.line_error      = line_err_q;
	assign result.sensors_on_line = cnt_out_q;

	`ASSERT_ALWAYS(a_integ_bounded, (int_q <= INTEG_HI_N) && (int_q >= INTEG_LO_N), "integral out of range")
	`ASSERT_SAME(a_fin_drained, state_q == S_FIN, !mac_rsp.busy, "result taken before last product added")
	`ASSERT_SAME(a_div_done_seen, (state_q == S_PID) && !zero_q, div_rsp.done, "error formed before divider done")

endmodule

`default_nettype wire
